// File: rtl/bfrv_pkg.sv
// Shared types and constants for the bounded FIFO with remove-by-value.
// Used by every module in rtl/; depends on nothing else.
package bfrv_pkg;

  // Fixed field widths of the request and result words
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned LIMIT_W  = 5;

  // Defaults for the top-level parameters
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Capacity limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Request modes (code 3 is unused and acts as a no-op)
  localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // Request word
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
  } req_t;

  // Result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  popped_value;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic load;    // write the bus value into this cell
    logic shift;   // take the younger neighbor's value
    logic cmp_en;  // capture the compare result against the bus value
  } cell_ctrl_t;

endpackage

// File: rtl/bfrv_cell.sv
// One storage cell of the FIFO chain: holds an entry, compares it, and
// shifts toward the head. Depends on bfrv_pkg.
module bfrv_cell import bfrv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] bus_data_i,
  input  logic [DATA_WIDTH-1:0] next_data_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  match_o
);

  logic [DATA_WIDTH-1:0] data_q;
  logic                  match_q;

  // Entry storage: load on push, take neighbor on pop/remove
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= bus_data_i;
    end else if (ctrl_i.shift) begin
      data_q <= next_data_i;
    end
  end

  // Registered compare for the remove search
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      match_q <= (data_q == bus_data_i);
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// File: rtl/bfrv_seek.sv
// Finds the oldest matching cell and builds the shift mask for a remove.
// Log-depth prefix OR over the match bits. Depends on bfrv_pkg.
module bfrv_seek import bfrv_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic [DEPTH-1:0] match_i,
  output logic [DEPTH-1:0] shift_o,
  output logic             found_o
);

  localparam int unsigned LV = $clog2(DEPTH);

  logic [DEPTH-1:0] pre [LV+1];

  // Prefix OR: bit i set when some cell at or below i matched
  always_comb begin
    pre[0] = match_i;
    for (int l = 0; l < LV; l++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
  end

  assign shift_o = pre[LV];
  assign found_o = pre[LV][DEPTH-1];

endmodule

// File: rtl/bounded_fifo_with_remove_by_value.sv
// Bounded FIFO with remove-by-value, built as a chain of shifting cells.
// Depends on bfrv_pkg, bfrv_cell and bfrv_seek.
//
// Request channel (in_valid_i / in_stall_o / in_word_i): push, pop or
// remove. Result channel (out_valid_o / out_stall_i / out_word_o): one word
// per request with status, popped value and occupancy after the request.
// Configuration: cfg_we_i writes cfg_wdata_i into the capacity limit; write
// only while the block is idle.
//
// Push, pop and the no-op mode finish at the accepting edge: their result
// is visible after that edge. In a remove, the cells first register their
// compares; then the oldest match is found and the entries above it shift
// down one place, and no request is taken until the search is done.
// Push and pop sustain one word per cycle while the result buffer has room.
// A two-word result buffer sits between the store and the result channel,
// so one request is still taken while a result waits; with two results
// waiting, in_stall_o stays high until the receiver drops out_stall_i.
// Reset empties the store, clears the result buffer and sets the limit
// to 16; no clearing pass is needed.
module bounded_fifo_with_remove_by_value import bfrv_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  req_t               in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsp_t               out_word_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEEK = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LIMIT_W-1:0] limit_q;

  logic                  in_acc;
  logic                  room;
  logic                  is_push, is_pop, is_remove;
  logic                  seek;
  logic [DATA_WIDTH-1:0] bus_data;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_match;
  logic [DEPTH-1:0]      match_vld;
  logic [DEPTH-1:0]      seek_shift;
  logic                  found;
  cell_ctrl_t            ctrl [DEPTH];

  logic res_wr;
  rsp_t res;

  rsp_t       oq_q [2];
  logic [1:0] oq_cnt_q, oq_cnt_d;
  logic       oq_pop;

  // Handshake and request decode
  assign in_stall_o = (state_q != S_IDLE) | (oq_cnt_q == 2'd2);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_push    = (in_word_i.mode == MODE_PUSH);
  assign is_pop     = (in_word_i.mode == MODE_POP);
  assign is_remove  = (in_word_i.mode == MODE_REMOVE);
  assign seek       = (state_q == S_SEEK);
  assign bus_data   = DATA_WIDTH'(in_word_i.value);
  assign room       = (cnt_q < CNT_W'(DEPTH)) & (CMP_W'(cnt_q) < CMP_W'(limit_q));

  // Capacity limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] nbr;

    if (i + 1 < DEPTH) begin : g_mid
      assign nbr = cell_data[i+1];
    end else begin : g_end
      assign nbr = cell_data[i];
    end

    assign ctrl[i].load   = in_acc & is_push & room & (cnt_q == CNT_W'(i));
    assign ctrl[i].shift  = (in_acc & is_pop & (cnt_q != '0))
                          | (seek & found & seek_shift[i]);
    assign ctrl[i].cmp_en = in_acc & is_remove;
    assign match_vld[i]   = cell_match[i] & (CNT_W'(i) < cnt_q);

    bfrv_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl[i]),
      .bus_data_i  (bus_data),
      .next_data_i (nbr),
      .data_o      (cell_data[i]),
      .match_o     (cell_match[i])
    );
  end

  // Oldest-match search
  bfrv_seek #(
    .DEPTH (DEPTH)
  ) u_seek (
    .match_i (match_vld),
    .shift_o (seek_shift),
    .found_o (found)
  );

  // Sequencer, occupancy and result word
  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    res_wr           = 1'b0;
    res.status       = ST_DONE;
    res.popped_value = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_wr = 1'b1;
          priority if (is_push) begin
            if (room) begin
              cnt_d = cnt_q + CNT_W'(1);
            end else begin
              res.status = ST_FULL;
            end
          end else if (is_pop) begin
            if (cnt_q != '0) begin
              cnt_d            = cnt_q - CNT_W'(1);
              res.popped_value = VALUE_W'(cell_data[0]);
            end else begin
              res.status = ST_EMPTY;
            end
          end else if (is_remove) begin
            res_wr  = 1'b0;
            state_d = S_SEEK;
          end else begin
            res.status = ST_DONE;
          end
        end
      end
      S_SEEK: begin
        res_wr  = 1'b1;
        state_d = S_IDLE;
        if (found) begin
          cnt_d = cnt_q - CNT_W'(1);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res.occupancy = OCC_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Two-word result buffer
  assign out_valid_o = (oq_cnt_q != 2'd0);
  assign out_word_o  = oq_q[0];
  assign oq_pop      = out_valid_o & ~out_stall_i;
  assign oq_cnt_d    = oq_cnt_q + {1'b0, res_wr} - {1'b0, oq_pop};

  always_ff @(posedge clk_i) begin
    if (oq_pop) begin
      oq_q[0] <= (res_wr && oq_cnt_q == 2'd1) ? res : oq_q[1];
    end else if (res_wr && oq_cnt_q == 2'd0) begin
      oq_q[0] <= res;
    end
    if (res_wr && (oq_cnt_q - {1'b0, oq_pop}) == 2'd1) begin
      oq_q[1] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_cnt_q <= 2'd0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
    end
  end

`ifndef SYNTHESIS
  // Occupancy never exceeds the physical depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  // A result is never written into a full result buffer
  a_oq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_wr && oq_cnt_q == 2'd2))
    else $error("result buffer overflow");

  // The search phase is always followed by the idle state
  a_seek_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seek |=> state_q == S_IDLE)
    else $error("search phase overran");

  // A push with room grows the store by one
  a_push_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_push && room) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("push did not grow occupancy");

  // No request is taken during the search phase
  a_seek_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seek |-> in_stall_o)
    else $error("request taken during search");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for bounded_fifo_with_remove_by_value.
// Depends on bfrv_pkg and the RTL top level; a scoreboard class mirrors the
// store contents, and plain tasks drive the request and config ports.
module testbench import bfrv_pkg::*;;

  // Unused mode code, acts as a no-op in the block
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  // Mirror of the store: predicts one result word per accepted request word
  class store_mirror;
    logic [VALUE_W-1:0] cells[$];
    logic [LIMIT_W-1:0] limit;
    rsp_t               expected_words[$];
    int unsigned        mismatches;
    int unsigned        words_checked;
    int unsigned        mode_seen[4];
    int unsigned        status_seen[4];
    int unsigned        peak_occupancy;

    function new();
      limit = LIMIT_RESET;
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void apply_request(req_t w);
      rsp_t want;
      int   hit;
      want = '0;
      want.status = ST_DONE;
      hit = -1;
      case (w.mode)
        MODE_PUSH: begin
          if (cells.size() >= limit || cells.size() >= DEPTH_DEF) want.status = ST_FULL;
          else cells.push_back(w.value);
        end
        MODE_POP: begin
          if (cells.size() == 0) want.status = ST_EMPTY;
          else want.popped_value = cells.pop_front();
        end
        MODE_REMOVE: begin
          // oldest equal entry goes, the younger ones close the gap
          foreach (cells[i]) if (hit < 0 && cells[i] == w.value) hit = i;
          if (hit < 0) want.status = ST_NOT_FOUND;
          else cells.delete(hit);
        end
        default: ;
      endcase
      want.occupancy = OCC_W'(cells.size());
      if (cells.size() > peak_occupancy) peak_occupancy = cells.size();
      mode_seen[w.mode]++;
      status_seen[want.status]++;
      expected_words.push_back(want);
    endfunction

    // Compare one result word with the oldest prediction
    function void check_word(rsp_t got);
      rsp_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result: status %0d value %h occupancy %0d",
                   $time, got.status, got.popped_value, got.occupancy);
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (got.status !== want.status || got.popped_value !== want.popped_value ||
          got.occupancy !== want.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected status %0d value %h occupancy %0d, got %0d %h %0d",
                   $time, want.status, want.popped_value, want.occupancy,
                   got.status, got.popped_value, got.occupancy);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  req_t               in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  rsp_t               out_word_o;

  store_mirror        mirror;
  int unsigned        idle_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        hold_left = 0;
  logic [VALUE_W-1:0] hot_vals[8];

  bounded_fifo_with_remove_by_value i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: long hold-offs counted here, random stalls otherwise
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Result monitor
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) mirror.check_word(out_word_o);
    end
  end

  // Run limit
  initial begin
    #3000000;
    $display("timeout: results still outstanding");
    $display("FAIL bounded_fifo_with_remove_by_value");
    $finish;
  end

  function automatic req_t request_word(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v);
    req_t w;
    w.mode  = m;
    w.value = v;
    return w;
  endfunction

  // Random request; values mostly from a small pool so removes find matches
  function automatic req_t random_word(int unsigned push_pct);
    req_t        w;
    int unsigned r;
    r = $urandom_range(99);
    w.value = $urandom;
    if (r < push_pct) begin
      w.mode = MODE_PUSH;
      if ($urandom_range(9) < 6) w.value = hot_vals[$urandom_range(7)];
    end else if (r < push_pct + (96 - push_pct) / 2) begin
      w.mode = MODE_POP;
    end else if (r < 96) begin
      w.mode = MODE_REMOVE;
      if ($urandom_range(9) < 8) w.value = hot_vals[$urandom_range(7)];
    end else begin
      w.mode = MODE_NOP;
    end
    return w;
  endfunction

  // Offer one request word and hold it until accepted
  task automatic send_word(input req_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mirror.apply_request(w);
  endtask

  // Stop offering and wait until every predicted word has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (mirror.expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Capacity limit write; only called with the block idle
  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mirror.limit = lim;
  endtask

  task automatic run_phase(int unsigned n, int unsigned idle, int unsigned stall,
                           int unsigned push_pct);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_word(random_word(push_pct));
  endtask

  // Main sequence
  initial begin
    mirror = new();
    hot_vals[0] = '0;
    hot_vals[1] = '1;
    for (int i = 2; i < 8; i++) hot_vals[i] = $urandom;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty store, no-op, duplicates, middle remove, extremes
    send_word(request_word(MODE_POP, '0));
    send_word(request_word(MODE_REMOVE, '0));
    send_word(request_word(MODE_NOP, '1));
    send_word(request_word(MODE_PUSH, '0));
    send_word(request_word(MODE_PUSH, '1));
    send_word(request_word(MODE_PUSH, 32'h5a5a_5a5a));
    send_word(request_word(MODE_PUSH, '0));
    send_word(request_word(MODE_REMOVE, '0));
    send_word(request_word(MODE_REMOVE, 32'h5a5a_5a5a));
    send_word(request_word(MODE_REMOVE, 32'h0000_0001));
    send_word(request_word(MODE_POP, 32'hdead_beef));

    // Limit of one: full on the second entry
    wait_drained();
    write_limit(5'd1);
    send_word(request_word(MODE_PUSH, 32'h7));
    send_word(request_word(MODE_POP, '0));
    send_word(request_word(MODE_PUSH, 32'h7));
    send_word(request_word(MODE_PUSH, 32'h8));

    // Limit zero: every push rejected
    wait_drained();
    write_limit(5'd0);
    send_word(request_word(MODE_PUSH, 32'h9));
    send_word(request_word(MODE_POP, '0));
    send_word(request_word(MODE_PUSH, 32'h9));

    // Limit above depth, then lowered below the occupancy
    wait_drained();
    write_limit(5'd31);
    send_word(request_word(MODE_PUSH, 32'h1));
    send_word(request_word(MODE_PUSH, 32'h2));
    send_word(request_word(MODE_PUSH, 32'h3));
    wait_drained();
    write_limit(5'd2);
    send_word(request_word(MODE_PUSH, 32'h4));
    send_word(request_word(MODE_POP, '0));
    send_word(request_word(MODE_PUSH, 32'h5));
    send_word(request_word(MODE_POP, '0));
    send_word(request_word(MODE_PUSH, 32'h4));

    // Random, no idling
    wait_drained();
    write_limit(5'd16);
    run_phase(170, 0, 0, 50);

    // Receiver holds off while the sender keeps offering: input must stall
    wait_drained();
    write_limit(5'd31);
    hold_left = 60;
    run_phase(20, 0, 0, 70);
    wait_drained();

    // Sender mostly idle; push-heavy to reach the physical depth
    run_phase(170, 72, 0, 58);

    // Receiver mostly stalling, random limit
    wait_drained();
    write_limit(5'($urandom_range(16, 1)));
    run_phase(170, 0, 72, 50);

    // Both sides idling now and then
    wait_drained();
    write_limit(5'd4);
    run_phase(170, 17, 17, 50);

    wait_drained();
    mirror.mismatches += mirror.expected_words.size();
    $display("Checked %0d results: %0d push, %0d pop, %0d remove, %0d no-op; peak fill %0d",
             mirror.words_checked, mirror.mode_seen[MODE_PUSH], mirror.mode_seen[MODE_POP],
             mirror.mode_seen[MODE_REMOVE], mirror.mode_seen[MODE_NOP],
             mirror.peak_occupancy);
    $display("Rejections: %0d full, %0d empty, %0d not found; limits 0 to 31; %0d mismatches",
             mirror.status_seen[ST_FULL], mirror.status_seen[ST_EMPTY],
             mirror.status_seen[ST_NOT_FOUND], mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("PASS bounded_fifo_with_remove_by_value");
    end else begin
      $display("FAIL bounded_fifo_with_remove_by_value");
    end
    $finish;
  end

endmodule
